// ----- src/rsacc_pkg.sv -----
// Shared types and constants for the RSA character cipher with key generation.
`timescale 1ns / 1ps
`default_nettype none
package rsacc_pkg;

	localparam logic [32:0] BIAS = 33'd96;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_PRIME = 2'd1;
	localparam logic [1:0] ST_NO_EXP = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;
	localparam logic REG_PRIME_P = 1'b0;
	localparam logic REG_PRIME_Q = 1'b1;
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_KEY_INIT, ST_PR_TEST, ST_PR_WAIT, ST_E_TEST, ST_E_WAIT,
		ST_D_DIV, ST_D_WAIT, ST_DISPATCH, ST_MP_BWAIT, ST_MP_LOOP, ST_MP_AD,
		ST_MP_AW, ST_MP_SQ, ST_MP_SD, ST_MP_SW, ST_FIN
	} state_t;

	typedef enum logic [1:0] {CTX_P, CTX_Q, CTX_I} ctx_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_KEY_INIT, CMD_PR_SETUP_Q, CMD_PR_SETUP_I,
		CMD_PR_START, CMD_PR_NEXT, CMD_FAIL_PRIME, CMD_FAIL_EXP, CMD_E_INIT,
		CMD_E_START, CMD_E_NEXT, CMD_D_INIT, CMD_D_START, CMD_D_NEXT, CMD_D_SET,
		CMD_MP_SETUP, CMD_MP_BSET, CMD_MP_MUL_AB, CMD_MP_MUL_BB, CMD_MP_DIVP,
		CMD_MP_ASET, CMD_MP_BSQ, CMD_FIN_OUT
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} ctrl_t;

	typedef struct packed {
		logic keys_ready;
		logic kstat_nz;
		logic range_bad;
		logic x_lt2;
		logic sq_gt_x;
		logic div_done;
		logic rem_zero;
		logic i_ge_t;
		logic i_is_pq;
		logic m_gt_e;
		logic ex_zero;
		logic ex_lsb;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- src/rsacc_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface rsacc_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic signed [31:0] data_value;
	modport source (output valid, output operation, output data_value, input ready);
	modport sink (input valid, input operation, input data_value, output ready);
endinterface

interface rsacc_out_if;
	logic valid;
	logic ready;
	logic signed [32:0] result_value;
	logic [7:0] shown_byte;
	logic [1:0] status;
	modport source (output valid, output result_value, output shown_byte, output status,
		input ready);
	modport sink (input valid, input result_value, input shown_byte, input status,
		output ready);
endinterface
`default_nettype wire

// ----- src/rsacc_div.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsacc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [63:0]      quotient,
	output logic [31:0]      remainder
);
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dq_q;
	logic [31:0] rem_q;
	logic [31:0] dv_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, dq_q[63]};
	assign ge = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, dv_q}) : trial[31:0];
			dq_q <= {dq_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = dq_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ----- src/rsacc_dp.sv -----
// Datapath: key registers, trial-division counters, square-and-multiply and result register.
`timescale 1ns / 1ps
`default_nettype none
module rsacc_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rsacc_pkg::ctrl_t   ctrl,
	output rsacc_pkg::dp_stat_t     stat,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_operation,
	input  wire logic signed [31:0] in_data_value,
	output logic signed [32:0]      res_value,
	output logic [7:0]              res_shown,
	output logic [1:0]              res_status
);
	logic [15:0] p_q, q_q;
	logic        keys_ready_q;
	logic [1:0]  kstat_q;
	logic [31:0] n_q, t_q, e_q, d_q, x_q, j_q, i_q, m_q, acc_q, b_q, ex_q;
	logic [63:0] sq_q, k_q, prod_q;
	logic        neg_q, op_q;
	logic [31:0] v_q;
	logic signed [32:0] res_q;
	logic [7:0]  shown_q;
	logic [1:0]  stat_q;

	logic        div_start, div_done;
	logic [63:0] div_dividend, div_quot;
	logic [31:0] div_divisor, div_rem;

	logic signed [32:0] base;
	logic [31:0] mag;
	logic [31:0] ex_sel;
	logic signed [32:0] r_signed;
	logic signed [32:0] r_biased;
	logic range_bad;

	rsacc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dividend), .divisor(div_divisor),
		.done(div_done), .quotient(div_quot), .remainder(div_rem)
	);

	assign base = (op_q == rsacc_pkg::OP_ENCRYPT) ? 33'($signed(v_q)) - $signed(rsacc_pkg::BIAS)
		: 33'($signed(v_q));
	assign mag = base[32] ? 32'(-base) : base[31:0];
	assign ex_sel = (op_q == rsacc_pkg::OP_ENCRYPT) ? e_q : d_q;
	assign range_bad = (op_q == rsacc_pkg::OP_ENCRYPT) && (v_q[31] || (v_q[30:7] != '0));
	assign r_signed = (neg_q && acc_q != '0) ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
	assign r_biased = r_signed + $signed(rsacc_pkg::BIAS);

	always_comb begin
		div_start = 1'b0;
		div_dividend = prod_q;
		div_divisor = n_q;
		unique case (ctrl.cmd)
			rsacc_pkg::CMD_PR_START: begin
				div_start = 1'b1;
				div_dividend = {32'd0, x_q};
				div_divisor = j_q;
			end
			rsacc_pkg::CMD_E_START: begin
				div_start = 1'b1;
				div_dividend = {32'd0, t_q};
				div_divisor = i_q;
			end
			rsacc_pkg::CMD_D_START: begin
				div_start = 1'b1;
				div_dividend = k_q;
				div_divisor = e_q;
			end
			rsacc_pkg::CMD_MP_SETUP: begin
				div_start = 1'b1;
				div_dividend = {32'd0, mag};
			end
			rsacc_pkg::CMD_MP_DIVP: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= 16'd2;
			q_q <= 16'd2;
			keys_ready_q <= 1'b0;
			kstat_q <= rsacc_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				keys_ready_q <= 1'b0;
				if (cfg_index == rsacc_pkg::REG_PRIME_P) p_q <= cfg_data;
				else q_q <= cfg_data;
			end
			unique case (ctrl.cmd)
				rsacc_pkg::CMD_KEY_INIT: begin
					keys_ready_q <= 1'b1;
					kstat_q <= rsacc_pkg::ST_OK;
				end
				rsacc_pkg::CMD_FAIL_PRIME: kstat_q <= rsacc_pkg::ST_NOT_PRIME;
				rsacc_pkg::CMD_FAIL_EXP: kstat_q <= rsacc_pkg::ST_NO_EXP;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			rsacc_pkg::CMD_LOAD: begin
				op_q <= in_operation;
				v_q <= in_data_value;
			end
			rsacc_pkg::CMD_KEY_INIT: begin
				n_q <= {16'd0, p_q} * {16'd0, q_q};
				t_q <= ({16'd0, p_q} - 32'd1) * ({16'd0, q_q} - 32'd1);
				e_q <= '0;
				d_q <= '0;
				x_q <= {16'd0, p_q};
				j_q <= 32'd2;
				sq_q <= 64'd4;
			end
			rsacc_pkg::CMD_PR_SETUP_Q: begin
				x_q <= {16'd0, q_q};
				j_q <= 32'd2;
				sq_q <= 64'd4;
			end
			rsacc_pkg::CMD_PR_SETUP_I: begin
				x_q <= i_q;
				j_q <= 32'd2;
				sq_q <= 64'd4;
			end
			rsacc_pkg::CMD_PR_NEXT: begin
				j_q <= j_q + 32'd1;
				sq_q <= sq_q + {31'd0, j_q, 1'b1};
			end
			rsacc_pkg::CMD_E_INIT: i_q <= 32'd2;
			rsacc_pkg::CMD_E_NEXT: i_q <= i_q + 32'd1;
			rsacc_pkg::CMD_D_INIT: begin
				e_q <= i_q;
				m_q <= 32'd1;
				k_q <= {32'd0, t_q} + 64'd1;
			end
			rsacc_pkg::CMD_D_NEXT: begin
				m_q <= m_q + 32'd1;
				k_q <= k_q + {32'd0, t_q};
			end
			rsacc_pkg::CMD_D_SET: d_q <= div_quot[31:0];
			rsacc_pkg::CMD_MP_SETUP: begin
				acc_q <= 32'd1;
				ex_q <= ex_sel;
				neg_q <= base[32] & ex_sel[0];
			end
			rsacc_pkg::CMD_MP_BSET: b_q <= div_rem;
			rsacc_pkg::CMD_MP_MUL_AB: prod_q <= acc_q * b_q;
			rsacc_pkg::CMD_MP_MUL_BB: prod_q <= b_q * b_q;
			rsacc_pkg::CMD_MP_ASET: acc_q <= div_rem;
			rsacc_pkg::CMD_MP_BSQ: begin
				b_q <= div_rem;
				ex_q <= {1'b0, ex_q[31:1]};
			end
			rsacc_pkg::CMD_FIN_OUT: begin
				if (kstat_q != rsacc_pkg::ST_OK) begin
					res_q <= '0;
					shown_q <= '0;
					stat_q <= kstat_q;
				end else if (range_bad) begin
					res_q <= '0;
					shown_q <= '0;
					stat_q <= rsacc_pkg::ST_RANGE;
				end else begin
					res_q <= (op_q == rsacc_pkg::OP_ENCRYPT) ? r_signed : r_biased;
					shown_q <= r_biased[7:0];
					stat_q <= rsacc_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	end

	// sq_q tracks j*j so the trial loop stops once j*j exceeds x
	assign stat.keys_ready = keys_ready_q;
	assign stat.kstat_nz = kstat_q != rsacc_pkg::ST_OK;
	assign stat.range_bad = range_bad;
	assign stat.x_lt2 = x_q < 32'd2;
	assign stat.sq_gt_x = sq_q > {32'd0, x_q};
	assign stat.div_done = div_done;
	assign stat.rem_zero = div_rem == '0;
	assign stat.i_ge_t = i_q >= t_q;
	assign stat.i_is_pq = (i_q == {16'd0, p_q}) || (i_q == {16'd0, q_q});
	assign stat.m_gt_e = m_q > e_q;
	assign stat.ex_zero = ex_q == '0;
	assign stat.ex_lsb = ex_q[0];

	assign res_value = res_q;
	assign res_shown = shown_q;
	assign res_status = stat_q;
endmodule
`default_nettype wire

// ----- src/rsacc_ctrl.sv -----
// Controller state machine: key derivation sequence, modular exponentiation and handshakes.
`timescale 1ns / 1ps
`default_nettype none
module rsacc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rsacc_pkg::dp_stat_t stat,
	output rsacc_pkg::ctrl_t         ctrl,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready
);
	rsacc_pkg::state_t state_q, state_d;
	rsacc_pkg::ctx_t   ctx_q, ctx_d;
	logic              full_q, full_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsacc_pkg::ST_IDLE;
			ctx_q <= rsacc_pkg::CTX_P;
			full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctx_q <= ctx_d;
			full_q <= full_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctx_d = ctx_q;
		ctrl.cmd = rsacc_pkg::CMD_NONE;
		in_ready = state_q == rsacc_pkg::ST_IDLE;
		full_d = full_q & ~out_ready;
		unique case (state_q)
			rsacc_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctrl.cmd = rsacc_pkg::CMD_LOAD;
					state_d = stat.keys_ready ? rsacc_pkg::ST_DISPATCH : rsacc_pkg::ST_KEY_INIT;
				end
			end
			rsacc_pkg::ST_KEY_INIT: begin
				ctrl.cmd = rsacc_pkg::CMD_KEY_INIT;
				ctx_d = rsacc_pkg::CTX_P;
				state_d = rsacc_pkg::ST_PR_TEST;
			end
			rsacc_pkg::ST_PR_TEST: begin
				if (stat.x_lt2) begin
					if (ctx_q == rsacc_pkg::CTX_I) begin
						ctrl.cmd = rsacc_pkg::CMD_E_NEXT;
						state_d = rsacc_pkg::ST_E_TEST;
					end else begin
						ctrl.cmd = rsacc_pkg::CMD_FAIL_PRIME;
						state_d = rsacc_pkg::ST_DISPATCH;
					end
				end else if (stat.sq_gt_x) begin
					// x is prime
					unique case (ctx_q)
						rsacc_pkg::CTX_P: begin
							ctrl.cmd = rsacc_pkg::CMD_PR_SETUP_Q;
							ctx_d = rsacc_pkg::CTX_Q;
						end
						rsacc_pkg::CTX_Q: begin
							ctrl.cmd = rsacc_pkg::CMD_E_INIT;
							state_d = rsacc_pkg::ST_E_TEST;
						end
						default: begin
							if (stat.i_is_pq) begin
								ctrl.cmd = rsacc_pkg::CMD_E_NEXT;
								state_d = rsacc_pkg::ST_E_TEST;
							end else begin
								ctrl.cmd = rsacc_pkg::CMD_D_INIT;
								state_d = rsacc_pkg::ST_D_DIV;
							end
						end
					endcase
				end else begin
					ctrl.cmd = rsacc_pkg::CMD_PR_START;
					state_d = rsacc_pkg::ST_PR_WAIT;
				end
			end
			rsacc_pkg::ST_PR_WAIT: begin
				if (stat.div_done) begin
					if (!stat.rem_zero) begin
						ctrl.cmd = rsacc_pkg::CMD_PR_NEXT;
						state_d = rsacc_pkg::ST_PR_TEST;
					end else if (ctx_q == rsacc_pkg::CTX_I) begin
						ctrl.cmd = rsacc_pkg::CMD_E_NEXT;
						state_d = rsacc_pkg::ST_E_TEST;
					end else begin
						ctrl.cmd = rsacc_pkg::CMD_FAIL_PRIME;
						state_d = rsacc_pkg::ST_DISPATCH;
					end
				end
			end
			rsacc_pkg::ST_E_TEST: begin
				if (stat.i_ge_t) begin
					ctrl.cmd = rsacc_pkg::CMD_FAIL_EXP;
					state_d = rsacc_pkg::ST_DISPATCH;
				end else begin
					ctrl.cmd = rsacc_pkg::CMD_E_START;
					state_d = rsacc_pkg::ST_E_WAIT;
				end
			end
			rsacc_pkg::ST_E_WAIT: begin
				if (stat.div_done) begin
					if (stat.rem_zero) begin
						ctrl.cmd = rsacc_pkg::CMD_E_NEXT;
						state_d = rsacc_pkg::ST_E_TEST;
					end else begin
						ctrl.cmd = rsacc_pkg::CMD_PR_SETUP_I;
						ctx_d = rsacc_pkg::CTX_I;
						state_d = rsacc_pkg::ST_PR_TEST;
					end
				end
			end
			rsacc_pkg::ST_D_DIV: begin
				if (stat.m_gt_e) begin
					ctrl.cmd = rsacc_pkg::CMD_FAIL_EXP;
					state_d = rsacc_pkg::ST_DISPATCH;
				end else begin
					ctrl.cmd = rsacc_pkg::CMD_D_START;
					state_d = rsacc_pkg::ST_D_WAIT;
				end
			end
			rsacc_pkg::ST_D_WAIT: begin
				if (stat.div_done) begin
					if (stat.rem_zero) begin
						ctrl.cmd = rsacc_pkg::CMD_D_SET;
						state_d = rsacc_pkg::ST_DISPATCH;
					end else begin
						ctrl.cmd = rsacc_pkg::CMD_D_NEXT;
						state_d = rsacc_pkg::ST_D_DIV;
					end
				end
			end
			rsacc_pkg::ST_DISPATCH: begin
				if (stat.kstat_nz || stat.range_bad) begin
					state_d = rsacc_pkg::ST_FIN;
				end else begin
					ctrl.cmd = rsacc_pkg::CMD_MP_SETUP;
					state_d = rsacc_pkg::ST_MP_BWAIT;
				end
			end
			rsacc_pkg::ST_MP_BWAIT: begin
				if (stat.div_done) begin
					ctrl.cmd = rsacc_pkg::CMD_MP_BSET;
					state_d = rsacc_pkg::ST_MP_LOOP;
				end
			end
			rsacc_pkg::ST_MP_LOOP: begin
				if (stat.ex_zero) begin
					state_d = rsacc_pkg::ST_FIN;
				end else if (stat.ex_lsb) begin
					ctrl.cmd = rsacc_pkg::CMD_MP_MUL_AB;
					state_d = rsacc_pkg::ST_MP_AD;
				end else begin
					state_d = rsacc_pkg::ST_MP_SQ;
				end
			end
			rsacc_pkg::ST_MP_AD: begin
				ctrl.cmd = rsacc_pkg::CMD_MP_DIVP;
				state_d = rsacc_pkg::ST_MP_AW;
			end
			rsacc_pkg::ST_MP_AW: begin
				if (stat.div_done) begin
					ctrl.cmd = rsacc_pkg::CMD_MP_ASET;
					state_d = rsacc_pkg::ST_MP_SQ;
				end
			end
			rsacc_pkg::ST_MP_SQ: begin
				ctrl.cmd = rsacc_pkg::CMD_MP_MUL_BB;
				state_d = rsacc_pkg::ST_MP_SD;
			end
			rsacc_pkg::ST_MP_SD: begin
				ctrl.cmd = rsacc_pkg::CMD_MP_DIVP;
				state_d = rsacc_pkg::ST_MP_SW;
			end
			rsacc_pkg::ST_MP_SW: begin
				if (stat.div_done) begin
					ctrl.cmd = rsacc_pkg::CMD_MP_BSQ;
					state_d = rsacc_pkg::ST_MP_LOOP;
				end
			end
			rsacc_pkg::ST_FIN: begin
				// wait for the result register to drain
				if (!full_q || out_ready) begin
					ctrl.cmd = rsacc_pkg::CMD_FIN_OUT;
					full_d = 1'b1;
					state_d = rsacc_pkg::ST_IDLE;
				end
			end
			default: state_d = rsacc_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = full_q;
endmodule
`default_nettype wire

// ----- src/rsa_char_cipher_with_keygen_unit.sv -----
// RSA character cipher with on-chip key generation: top level.
// Usage:
//   cfg_we/cfg_index/cfg_data write prime_p (index 0) or prime_q (index 1); a write
//   marks the keys stale. Write only while the block is idle.
//   in_ch carries one item: operation (0 encrypt, 1 decrypt) and data_value.
//   out_ch returns one result item per input item: result_value, shown_byte, status.
// Operation:
//   The first item after a prime write first derives keys: trial division of p and
//   q, search for e, search for d, each step one divide on the shared divider.
//   Then square-and-multiply runs one or two 32x32 multiplies, each followed by a
//   remainder on that divider, per exponent bit up to the top set bit of the exponent.
//   Error items (bad prime, no exponent, out-of-range character) skip the exponent loop.
// Throughput: one item at a time; in_ch.ready is high only in the idle state.
// A finished result sits in the output register, so the next item can be taken
// and processed while out_ch is stalled; the block then waits before writing
// its next result.
// Reset: primes return to 2, keys are marked stale, both channels go idle.
`timescale 1ns / 1ps
`default_nettype none
module rsa_char_cipher_with_keygen_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_data,
	rsacc_in_if.sink          in_ch,
	rsacc_out_if.source       out_ch
);
	rsacc_pkg::ctrl_t    ctrl;
	rsacc_pkg::dp_stat_t stat;

	rsacc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .stat(stat), .ctrl(ctrl),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready)
	);

	rsacc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_operation(in_ch.operation), .in_data_value(in_ch.data_value),
		.res_value(out_ch.result_value), .res_shown(out_ch.shown_byte),
		.res_status(out_ch.status)
	);
endmodule
`default_nettype wire

// ----- tb/sv/rsacc_checker.sv -----
// Predictor and result comparison for the RSA character cipher.
`timescale 1ns / 1ps
module rsacc_checker import rsacc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [15:0] cfg_data,
	rsacc_in_if in_ch,
	rsacc_out_if out_ch,
	output int errors,
	output int pending
);
	typedef struct packed {
		logic signed [32:0] value;
		logic [7:0] shown;
		logic [1:0] status;
	} cipher_res_t;

	logic [15:0] p_reg, q_reg;
	bit keys_ok;
	logic [1:0] kstat;
	longint unsigned mod_n, tot, exp_e, exp_d;
	cipher_res_t cipher_q[$];

	function automatic bit is_prime_num(longint unsigned x);
		longint unsigned i;
		if (x < 2) return 0;
		for (i = 2; i * i <= x; i++)
			if (x % i == 0) return 0;
		return 1;
	endfunction

	task automatic make_keys();
		longint unsigned i, e, m, k;
		e = 0;
		keys_ok = 1;
		kstat = ST_OK;
		exp_e = 0;
		exp_d = 0;
		mod_n = (longint'(p_reg) * q_reg) & 64'hFFFF_FFFF;
		tot = (((longint'(p_reg) - 1) & 64'hFFFF_FFFF) * ((longint'(q_reg) - 1) & 64'hFFFF_FFFF))
			& 64'hFFFF_FFFF;
		if (!is_prime_num(p_reg) || !is_prime_num(q_reg)) begin
			kstat = ST_NOT_PRIME;
			return;
		end
		for (i = 2; i < tot; i++) begin
			if (tot % i == 0) continue;
			if (is_prime_num(i) && i != p_reg && i != q_reg) begin
				e = i;
				break;
			end
		end
		if (e == 0) begin
			kstat = ST_NO_EXP;
			return;
		end
		for (m = 1; m <= e; m++) begin
			k = 1 + m * tot;
			if (k % e == 0) begin
				exp_e = e;
				exp_d = (k / e) & 64'hFFFF_FFFF;
				return;
			end
		end
		kstat = ST_NO_EXP;
	endtask

	// magnitude only; the caller restores the sign of a negative base with odd exponent
	function automatic longint signed_pow_mod(longint base, longint unsigned ex);
		longint unsigned mag, acc, b;
		mag = (base < 0) ? longint'(-base) : longint'(base);
		acc = 1 % mod_n;
		b = mag % mod_n;
		while (ex != 0) begin
			if (ex[0]) acc = (acc * b) % mod_n;
			b = (b * b) % mod_n;
			ex = ex >> 1;
		end
		return acc;
	endfunction

	function automatic cipher_res_t predict_cipher(logic op, logic signed [31:0] dv);
		cipher_res_t r;
		longint v, res;
		longint unsigned ex;
		v = dv;
		r = '0;
		if (kstat != ST_OK) begin
			r.status = kstat;
			return r;
		end
		if (op == OP_ENCRYPT) begin
			if (v < 0 || v > 127) begin
				r.status = ST_RANGE;
				return r;
			end
			ex = exp_e;
			res = signed_pow_mod(v - 96, ex);
			if (v - 96 < 0 && ex[0] && res != 0) res = -res;
			r.shown = 8'(res + 96);
		end else begin
			ex = exp_d;
			res = signed_pow_mod(v, ex);
			if (v < 0 && ex[0] && res != 0) res = -res;
			res = res + 96;
			r.shown = 8'(res);
		end
		r.value = 33'(res);
		r.status = ST_OK;
		return r;
	endfunction

	assign pending = cipher_q.size();

	always @(posedge clk or negedge arst_n) begin
		cipher_res_t want, got;
		if (!arst_n) begin
			p_reg <= 16'd2;
			q_reg <= 16'd2;
			keys_ok = 0;
			kstat = ST_OK;
			errors <= 0;
			cipher_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PRIME_P) p_reg <= cfg_data;
				else p_reg <= p_reg;
				if (cfg_index == REG_PRIME_Q) q_reg <= cfg_data;
				keys_ok = 0;
			end
			if (in_ch.valid && in_ch.ready) begin
				if (!keys_ok) make_keys();
				cipher_q.push_back(predict_cipher(in_ch.operation, in_ch.data_value));
			end
			if (out_ch.valid && out_ch.ready) begin
				got.value = out_ch.result_value;
				got.shown = out_ch.shown_byte;
				got.status = out_ch.status;
				if (cipher_q.size() == 0) begin
					if (errors < 10) $display("unexpected result item %h", got);
					errors <= errors + 1;
				end else begin
					want = cipher_q.pop_front();
					if (want !== got) begin
						if (errors < 10)
							$display({"result mismatch: expected value %0d byte %0d",
								" status %0d, got value %0d byte %0d status %0d"},
								want.value, want.shown, want.status,
								got.value, got.shown, got.status);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ----- tb/sv/testbench.sv -----
// Stimulus, pacing and verdict for the RSA character cipher block.
`timescale 1ns / 1ps
module testbench;
	import rsacc_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam int LONG_HOLD = 12000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = REG_PRIME_P;
	logic [15:0] cfg_data = '0;
	int errors, pending, idle_cycles;
	bit hold_req = 0, burst_mode = 0;
	longint unsigned cur_n = 4;

	rsacc_in_if in_ch();
	rsacc_out_if out_ch();

	rsa_char_cipher_with_keygen_unit dut (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_ch(in_ch.sink), .out_ch(out_ch.source));

	rsacc_checker chk (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_ch, .out_ch,
		.errors, .pending);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.operation = OP_ENCRYPT;
		in_ch.data_value = '0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side pacing
	initial begin
		int gap;
		idle_cycles = 0;
		@(posedge arst_n);
		@(posedge clk);
		out_ch.ready <= 1;
		forever begin
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
			gap = burst_mode ? 0 : $urandom_range(0, 5);
			if (hold_req) begin
				gap = LONG_HOLD;
				hold_req = 0;
			end
			if (gap > 0) begin
				out_ch.ready <= 0;
				repeat (gap) @(posedge clk);
				out_ch.ready <= 1;
			end
		end
	end

	task automatic send_item(logic op, logic signed [31:0] dv);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.operation <= op;
		in_ch.data_value <= dv;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain_block();
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_primes(logic [15:0] p, logic [15:0] q);
		cfg_we <= 1;
		cfg_index <= REG_PRIME_P;
		cfg_data <= p;
		@(posedge clk);
		cfg_index <= REG_PRIME_Q;
		cfg_data <= q;
		@(posedge clk);
		cfg_we <= 0;
		cur_n = longint'(p) * q;
		@(posedge clk);
	endtask

	task automatic random_item();
		int pick;
		logic signed [31:0] dv;
		pick = $urandom_range(0, 99);
		if (pick < 45) send_item(OP_ENCRYPT, $urandom_range(0, 127));
		else if (pick < 80) begin
			dv = $urandom_range(0, 32'(cur_n - 1));
			if ($urandom_range(0, 1)) dv = -dv;
			send_item(OP_DECRYPT, dv);
		end else if (pick < 90) send_item(OP_ENCRYPT, $urandom);
		else send_item(OP_DECRYPT, $urandom);
	endtask

	initial begin
		logic [15:0] key_p[8] = '{16'd3, 16'd61, 16'd46337, 16'd46337, 16'd101, 0, 0, 0};
		logic [15:0] key_q[8] = '{16'd5, 16'd53, 16'd3, 16'd46337, 16'd113, 0, 0, 0};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset primes 2 and 2: no exponent exists
		send_item(OP_ENCRYPT, 32'd97);
		send_item(OP_DECRYPT, 32'd5);
		drain_block();
		set_primes(16'd0, 16'd7);
		send_item(OP_ENCRYPT, 32'd98);
		drain_block();
		set_primes(16'd1, 16'd1);
		send_item(OP_DECRYPT, 32'd1);
		drain_block();
		set_primes(16'd46340, 16'd3);
		send_item(OP_ENCRYPT, 32'd100);
		drain_block();
		set_primes(16'd2, 16'd3);
		send_item(OP_ENCRYPT, 32'd100);
		send_item(OP_DECRYPT, 32'd3);
		drain_block();
		set_primes(16'd3, 16'd5);
		send_item(OP_ENCRYPT, 32'd0);
		send_item(OP_ENCRYPT, 32'd127);
		send_item(OP_ENCRYPT, 32'd128);
		send_item(OP_ENCRYPT, -32'sd1);
		send_item(OP_ENCRYPT, 32'd96);
		send_item(OP_DECRYPT, 32'h7FFF_FFFF);
		send_item(OP_DECRYPT, 32'h8000_0000);
		send_item(OP_DECRYPT, 32'h8000_0001);
		send_item(OP_DECRYPT, 32'd0);
		send_item(OP_DECRYPT, -32'sd14);
		drain_block();
		for (int ph = 0; ph < 5; ph++) begin
			set_primes(key_p[ph], key_q[ph]);
			burst_mode = 0;
			for (int k = 0; k < 24; k++) begin
				if (k % 8 == 0) burst_mode = ($urandom_range(0, 2) == 0);
				if (ph == 1 && k == 4) hold_req = 1;
				if (ph == 2 && k == 10) begin
					in_ch.valid <= 0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				random_item();
			end
			drain_block();
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- sim.f -----
src/rsacc_pkg.sv
src/rsacc_if.sv
src/rsacc_div.sv
src/rsacc_dp.sv
src/rsacc_ctrl.sv
src/rsa_char_cipher_with_keygen_unit.sv
tb/sv/rsacc_checker.sv
tb/sv/testbench.sv
